// File: rtl/core/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
// Used by sem_isqrt and sobel_edge_magnitude; no dependencies.
`default_nettype none

package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_W      = 13;
    localparam int PIX_W      = 8;

    localparam int SQ_W       = 2 * PIX_W + 1;
    localparam int RACC_W     = SQ_W + 1;
    localparam int ROOT_W     = PIX_W + 1;

    localparam logic       OP_PIXEL = 1'b0;
    localparam logic       OP_FLUSH = 1'b1;

    localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [PIX_W-1:0] pixel_in;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_mag;
        logic             row_end;
        logic             frame_end;
    } out_word_t;

endpackage

`default_nettype wire

// File: rtl/core/sem_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on sem_pkg.
`default_nettype none

module sem_isqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [sem_pkg::SQ_W-1:0]      value,
    output logic                               done,
    output logic [sem_pkg::ROOT_W-1:0]         root
);

    logic                        busy_reg;
    logic                        busy_next;
    logic                        done_reg;
    logic                        done_next;
    logic [sem_pkg::SQ_W-1:0]    v_reg;
    logic [sem_pkg::SQ_W-1:0]    v_next;
    logic [sem_pkg::RACC_W-1:0]  r_reg;
    logic [sem_pkg::RACC_W-1:0]  r_next;
    logic [sem_pkg::SQ_W-1:0]    bit_reg;
    logic [sem_pkg::SQ_W-1:0]    bit_next;
    logic [sem_pkg::RACC_W-1:0]  trial;

    assign trial = r_reg + {1'b0, bit_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            v_next    = value;
            r_next    = '0;
            bit_next  = {1'b1, {(sem_pkg::SQ_W-1){1'b0}}};
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next = v_reg - trial[sem_pkg::SQ_W-1:0];
                r_next = {1'b0, r_reg[sem_pkg::RACC_W-1:1]} + {1'b0, bit_reg};
            end
            else
            begin
                r_next = {1'b0, r_reg[sem_pkg::RACC_W-1:1]};
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg[sem_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/sobel_edge_magnitude.sv
// Top level of the streaming 3x3 Sobel edge magnitude block.
// Depends on sem_pkg and sem_isqrt.
`default_nettype none

// Pixels enter in raster order, frame_width per row, frame_height rows per frame;
// results trail by frame_width+1 words, and frame_width+1 flush words after the
// last pixel drain the final row (any word is taken as a flush while draining).
// One word is in flight at a time. A word that yields a magnitude reaches the output
// register through line-store read, gradient, square, nine steps of the serial
// square-root unit, then the result register, and waits there while the output
// register is full; the next word is taken once the result is loaded. A pixel that
// yields no result returns to idle after the line-store read, and an ignored flush is
// taken without leaving idle. The output register lets the next word be accepted while
// a result waits. Writing either register restarts the frame and drops pending results.
// Line-store contents before row 0 of a frame are never read, so the store needs no clearing after reset.
module sobel_edge_magnitude (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire sem_pkg::in_word_t           in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output sem_pkg::out_word_t               out_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [sem_pkg::CFG_W-1:0]   cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_PUT  = 3'd4;

    typedef struct packed {
        logic [sem_pkg::ADDR_W-1:0] addr;
        logic                       do_shift;
        logic                       fill;
        logic                       rb;
        logic                       emit;
        logic                       use_q;
        logic                       bot_px;
        logic                       do_write;
        logic                       row_end;
        logic                       frame_end;
    } step_ctl_t;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;

    logic [sem_pkg::FW_W-1:0]    frame_width_reg;
    logic [sem_pkg::FH_W-1:0]    frame_height_reg;
    logic [sem_pkg::ADDR_W-1:0]  in_col_reg;
    logic [sem_pkg::ADDR_W-1:0]  in_col_next;
    logic [sem_pkg::ROW_W-1:0]   in_row_reg;
    logic [sem_pkg::ROW_W-1:0]   in_row_next;
    logic [sem_pkg::ADDR_W-1:0]  out_col_reg;
    logic [sem_pkg::ADDR_W-1:0]  out_col_next;
    logic [sem_pkg::ROW_W-1:0]   out_row_reg;
    logic [sem_pkg::ROW_W-1:0]   out_row_next;

    logic [sem_pkg::FW_W-1:0]    wd;
    logic [sem_pkg::FH_W-1:0]    ht;
    logic [sem_pkg::FW_W-1:0]    in_col_inc;
    logic [sem_pkg::FH_W-1:0]    in_row_inc;
    logic [sem_pkg::FW_W-1:0]    out_col_inc;
    logic [sem_pkg::FH_W-1:0]    out_row_inc;
    logic                        out_last_col;
    logic                        out_last_row;
    logic                        draining;
    logic                        accept;
    logic                        cfg_write;

    step_ctl_t                   ctl_reg;
    step_ctl_t                   ctl_next;
    logic                        need_rd;
    logic                        adv_out;
    logic [sem_pkg::PIX_W-1:0]   px_reg;

    logic [2*sem_pkg::PIX_W-1:0] line_mem [sem_pkg::MAX_WIDTH];
    logic [2*sem_pkg::PIX_W-1:0] q_reg;
    logic [2*sem_pkg::PIX_W-1:0] mem_wdata;
    logic                        mem_we;

    logic [sem_pkg::PIX_W-1:0]   win_reg [9];
    logic [sem_pkg::PIX_W-1:0]   new_win [9];
    logic [sem_pkg::PIX_W-1:0]   ew [9];
    logic [sem_pkg::PIX_W-1:0]   col_v [3];
    logic [11:0]                 gx;
    logic [11:0]                 gy;
    logic [sem_pkg::PIX_W-1:0]   ax_clamp;
    logic [sem_pkg::PIX_W-1:0]   ay_clamp;
    logic [sem_pkg::PIX_W-1:0]   ax_reg;
    logic [sem_pkg::PIX_W-1:0]   ay_reg;
    logic [2*sem_pkg::PIX_W-1:0] ax_sq;
    logic [2*sem_pkg::PIX_W-1:0] ay_sq;
    logic [sem_pkg::SQ_W-1:0]    sq_sum;

    logic                        sqrt_start;
    logic                        sqrt_done;
    logic [sem_pkg::ROOT_W-1:0]  sqrt_root;
    logic [sem_pkg::PIX_W-1:0]   mag_reg;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    sem_pkg::out_word_t          out_data_reg;
    logic                        out_load;

    // effective frame size
    always_comb
    begin
        if (frame_width_reg < sem_pkg::FW_W'(3))
            wd = sem_pkg::FW_W'(3);
        else if (frame_width_reg > sem_pkg::FW_W'(sem_pkg::MAX_WIDTH))
            wd = sem_pkg::FW_W'(sem_pkg::MAX_WIDTH);
        else
            wd = frame_width_reg;
        if (frame_height_reg < sem_pkg::FH_W'(3))
            ht = sem_pkg::FH_W'(3);
        else if (frame_height_reg > sem_pkg::FH_W'(sem_pkg::MAX_HEIGHT))
            ht = sem_pkg::FH_W'(sem_pkg::MAX_HEIGHT);
        else
            ht = frame_height_reg;
    end

    assign in_col_inc   = {1'b0, in_col_reg} + sem_pkg::FW_W'(1);
    assign in_row_inc   = {1'b0, in_row_reg} + sem_pkg::FH_W'(1);
    assign out_col_inc  = {1'b0, out_col_reg} + sem_pkg::FW_W'(1);
    assign out_row_inc  = {1'b0, out_row_reg} + sem_pkg::FH_W'(1);
    assign out_last_col = out_col_inc >= wd;
    assign out_last_row = out_row_inc >= ht;
    assign draining     = (in_col_reg == '0) && (in_row_reg == '0)
                          && ((out_col_reg != '0) || (out_row_reg != '0));

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // decode of an accepted word
    always_comb
    begin
        ctl_next           = '0;
        ctl_next.row_end   = out_last_col;
        ctl_next.frame_end = out_last_col && out_last_row;
        need_rd            = 1'b0;
        adv_out            = 1'b0;
        in_col_next        = in_col_reg;
        in_row_next        = in_row_reg;
        if (draining)
        begin
            need_rd           = 1'b1;
            adv_out           = 1'b1;
            ctl_next.addr     = out_last_col ? '0 : out_col_inc[sem_pkg::ADDR_W-1:0];
            ctl_next.do_shift = !out_last_col || !out_last_row;
            ctl_next.fill     = out_last_col;
            ctl_next.rb       = out_last_col;
            ctl_next.emit     = 1'b1;
            ctl_next.use_q    = 1'b1;
        end
        else if (in_data.opcode == sem_pkg::OP_PIXEL)
        begin
            need_rd           = 1'b1;
            ctl_next.addr     = in_col_reg;
            ctl_next.do_shift = 1'b1;
            ctl_next.fill     = (in_col_reg == '0);
            ctl_next.rb       = (in_col_reg == '0) && (in_row_reg >= sem_pkg::ROW_W'(2));
            ctl_next.emit     = ctl_next.rb || ((in_col_reg != '0) && (in_row_reg != '0));
            ctl_next.use_q    = (in_row_reg != '0);
            ctl_next.bot_px   = 1'b1;
            ctl_next.do_write = 1'b1;
            adv_out           = ctl_next.emit;
            if (in_col_inc >= wd)
            begin
                in_col_next = '0;
                in_row_next = (in_row_inc >= ht) ? '0 : in_row_inc[sem_pkg::ROW_W-1:0];
            end
            else
            begin
                in_col_next = in_col_inc[sem_pkg::ADDR_W-1:0];
            end
        end
        if (out_last_col)
        begin
            out_col_next = '0;
            out_row_next = out_last_row ? '0 : out_row_inc[sem_pkg::ROW_W-1:0];
        end
        else
        begin
            out_col_next = out_col_inc[sem_pkg::ADDR_W-1:0];
            out_row_next = out_row_reg;
        end
    end

    // line store: upper row in the high byte, middle row in the low byte
    assign mem_we = (state_reg == ST_RD) && ctl_reg.do_write;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[ctl_reg.addr] <= mem_wdata;
        if (accept)
            q_reg <= line_mem[ctl_next.addr];
    end

    // new column, window shift and gradients
    always_comb
    begin
        col_v[0]  = ctl_reg.use_q ? q_reg[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W] : px_reg;
        col_v[1]  = ctl_reg.use_q ? q_reg[sem_pkg::PIX_W-1:0] : px_reg;
        col_v[2]  = ctl_reg.bot_px ? px_reg : q_reg[sem_pkg::PIX_W-1:0];
        mem_wdata = {col_v[1], px_reg};
        for (int r = 0; r < 3; r++)
        begin
            if (ctl_reg.fill)
            begin
                new_win[r*3]     = col_v[r];
                new_win[r*3 + 1] = col_v[r];
            end
            else
            begin
                new_win[r*3]     = win_reg[r*3 + 1];
                new_win[r*3 + 1] = win_reg[r*3 + 2];
            end
            new_win[r*3 + 2] = col_v[r];
            if (ctl_reg.rb)
            begin
                ew[r*3]     = win_reg[r*3 + 1];
                ew[r*3 + 1] = win_reg[r*3 + 2];
                ew[r*3 + 2] = win_reg[r*3 + 2];
            end
            else
            begin
                ew[r*3]     = new_win[r*3];
                ew[r*3 + 1] = new_win[r*3 + 1];
                ew[r*3 + 2] = new_win[r*3 + 2];
            end
        end
        gx = ({4'b0, ew[2]} + {3'b0, ew[5], 1'b0} + {4'b0, ew[8]})
             - ({4'b0, ew[0]} + {3'b0, ew[3], 1'b0} + {4'b0, ew[6]});
        gy = ({4'b0, ew[0]} + {3'b0, ew[1], 1'b0} + {4'b0, ew[2]})
             - ({4'b0, ew[6]} + {3'b0, ew[7], 1'b0} + {4'b0, ew[8]});
        if (gx[11])
            ax_clamp = '0;
        else if (gx[10:8] != 3'b0)
            ax_clamp = '1;
        else
            ax_clamp = gx[7:0];
        if (gy[11])
            ay_clamp = '0;
        else if (gy[10:8] != 3'b0)
            ay_clamp = '1;
        else
            ay_clamp = gy[7:0];
    end

    assign ax_sq      = {8'b0, ax_reg} * {8'b0, ax_reg};
    assign ay_sq      = {8'b0, ay_reg} * {8'b0, ay_reg};
    assign sq_sum     = {1'b0, ax_sq} + {1'b0, ay_sq};
    assign sqrt_start = (state_reg == ST_MUL);

    sem_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (sq_sum),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign out_load = (state_reg == ST_PUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && need_rd)
                    state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ctl_reg.emit ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                    state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frame_width_reg  <= sem_pkg::FW_W'(512);
            frame_height_reg <= sem_pkg::FH_W'(512);
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    sem_pkg::CFG_FRAME_WIDTH:
                        frame_width_reg <= cfg_data[sem_pkg::FW_W-1:0];
                    sem_pkg::CFG_FRAME_HEIGHT:
                        frame_height_reg <= cfg_data[sem_pkg::FH_W-1:0];
                    default:
                        frame_width_reg <= frame_width_reg;
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else if (accept)
            begin
                in_col_reg <= in_col_next;
                in_row_reg <= in_row_next;
                if (adv_out)
                begin
                    out_col_reg <= out_col_next;
                    out_row_reg <= out_row_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg <= ctl_next;
            px_reg  <= in_data.pixel_in;
        end
        if ((state_reg == ST_RD) && ctl_reg.do_shift)
        begin
            for (int j = 0; j < 9; j++)
                win_reg[j] <= new_win[j];
        end
        if (state_reg == ST_RD)
        begin
            ax_reg <= ax_clamp;
            ay_reg <= ay_clamp;
        end
        if ((state_reg == ST_SQRT) && sqrt_done)
            mag_reg <= sqrt_root[sem_pkg::ROOT_W-1] ? '1 : sqrt_root[sem_pkg::PIX_W-1:0];
        if (out_load)
        begin
            out_data_reg.edge_mag  <= mag_reg;
            out_data_reg.row_end   <= ctl_reg.row_end;
            out_data_reg.frame_end <= ctl_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_put_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT && !out_valid_reg) |=> (state_reg == ST_IDLE && out_valid))
        else $error("result not loaded into empty output register");

    a_mul_to_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_SQRT && !sqrt_done))
        else $error("square root unit not started");

    a_done_in_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == ST_SQRT))
        else $error("square root finished outside its wait state");

    a_rd_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD && !ctl_reg.emit) |=> (state_reg == ST_IDLE))
        else $error("word without result did not return to idle");

endmodule

`default_nettype wire

// File: tb/sv/tb_sobel_edge_magnitude.sv
`timescale 1ns / 1ps
// Self-checking testbench for sobel_edge_magnitude: directed and random pixel frames
// with flush drains, magnitudes predicted by a scoreboard class and checked word by word.
// Depends on sem_pkg and the sobel_edge_magnitude RTL only.

module tb_sobel_edge_magnitude;
    import sem_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 3000000;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          HOLD_CYCLES   = 500;
    localparam int unsigned RANDOM_WORDS  = 700;

    typedef logic [PIX_W-1:0] nbhd_t [9];

    class mag_scoreboard;
        logic [PIX_W-1:0] upper_line [MAX_WIDTH];
        logic [PIX_W-1:0] middle_line [MAX_WIDTH];
        nbhd_t            win;
        int unsigned      width_reg, height_reg;
        int unsigned      in_col, in_row, out_col, out_row;
        out_word_t        mag_queue [$];
        int unsigned      errors, checked, words;

        function new();
            foreach (upper_line[n])
            begin
                upper_line[n]  = '0;
                middle_line[n] = '0;
            end
            foreach (win[n])
                win[n] = '0;
            width_reg  = 512;
            height_reg = 512;
            in_col     = 0;
            in_row     = 0;
            out_col    = 0;
            out_row    = 0;
            errors     = 0;
            checked    = 0;
            words      = 0;
        endfunction

        static function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            return (v < 3) ? 3 : ((v > hi) ? hi : v);
        endfunction

        function void write_reg(logic [0:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_FRAME_WIDTH)
                width_reg = data[FW_W-1:0];
            else
                height_reg = data[FH_W-1:0];
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        // first: column zero, left and centre columns take the new column too
        function void shift_in(bit first, logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
                               logic [PIX_W-1:0] b);
            logic [PIX_W-1:0] v [3];
            v[0] = t;
            v[1] = m;
            v[2] = b;
            for (int r = 0; r < 3; r++)
            begin
                if (first)
                begin
                    win[r*3]   = v[r];
                    win[r*3+1] = v[r];
                end
                else
                begin
                    win[r*3]   = win[r*3+1];
                    win[r*3+1] = win[r*3+2];
                end
                win[r*3+2] = v[r];
            end
        endfunction

        // border: right edge, window columns centre, right, right
        function void emit(bit border, int unsigned wd, int unsigned ht);
            nbhd_t     w;
            out_word_t r;
            int        gx, gy, ax, ay, sum, root;
            for (int n = 0; n < 3; n++)
            begin
                w[n*3]   = border ? win[n*3+1] : win[n*3];
                w[n*3+1] = border ? win[n*3+2] : win[n*3+1];
                w[n*3+2] = win[n*3+2];
            end
            gx = int'(w[2]) - int'(w[0]) + 2 * (int'(w[5]) - int'(w[3]))
                 + int'(w[8]) - int'(w[6]);
            gy = int'(w[0]) + 2 * int'(w[1]) + int'(w[2])
                 - int'(w[6]) - 2 * int'(w[7]) - int'(w[8]);
            ax = (gx < 0) ? 0 : ((gx > 255) ? 255 : gx);
            ay = (gy < 0) ? 0 : ((gy > 255) ? 255 : gy);
            sum = ax * ax + ay * ay;
            root = 0;
            while ((root + 1) * (root + 1) <= sum)
                root++;
            if (root > 255)
                root = 255;
            r.edge_mag  = root[PIX_W-1:0];
            r.row_end   = (out_col + 1 >= wd);
            r.frame_end = r.row_end && (out_row + 1 >= ht);
            mag_queue.push_back(r);
            out_col++;
            if (out_col >= wd)
            begin
                out_col = 0;
                out_row++;
                if (out_row >= ht)
                    out_row = 0;
            end
        endfunction

        function void take_word(in_word_t wd_in);
            int unsigned      wd, ht, k, i;
            bit               last;
            logic [PIX_W-1:0] t, m, p;
            wd = clamp_dim(width_reg, MAX_WIDTH);
            ht = clamp_dim(height_reg, MAX_HEIGHT);
            k = in_col;
            i = in_row;
            p = wd_in.pixel_in;
            words++;
            // draining: any word releases one pending output
            if (i == 0 && k == 0 && (out_row != 0 || out_col != 0))
            begin
                if (out_col + 1 >= wd)
                begin
                    last = (out_row + 1 >= ht);
                    emit(1'b1, wd, ht);
                    if (!last)
                        shift_in(1'b1, upper_line[0], middle_line[0], middle_line[0]);
                end
                else
                begin
                    k = out_col + 1;
                    shift_in(1'b0, upper_line[k], middle_line[k], middle_line[k]);
                    emit(1'b0, wd, ht);
                end
                return;
            end
            if (wd_in.opcode == OP_FLUSH)
                return;
            if (k >= wd || i >= ht)
            begin
                k = 0;
                i = 0;
            end
            if (k == 0 && i >= 2)
                emit(1'b1, wd, ht);
            if (i == 0)
            begin
                t = p;
                m = p;
                upper_line[k]  = p;
                middle_line[k] = p;
            end
            else
            begin
                t = upper_line[k];
                m = middle_line[k];
                upper_line[k]  = m;
                middle_line[k] = p;
            end
            shift_in(k == 0, t, m, p);
            if (k >= 1 && i >= 1)
                emit(1'b0, wd, ht);
            k++;
            if (k >= wd)
            begin
                k = 0;
                i++;
                if (i >= ht)
                    i = 0;
            end
            in_col = k;
            in_row = i;
        endfunction

        function void check_word(out_word_t got);
            out_word_t exp_w;
            if (mag_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result mag %0d row_end %0b frame_end %0b",
                         $time, got.edge_mag, got.row_end, got.frame_end);
                return;
            end
            exp_w = mag_queue.pop_front();
            checked++;
            if (got.edge_mag !== exp_w.edge_mag)
            begin
                errors++;
                $display("%0t: edge_mag expected %0d got %0d",
                         $time, exp_w.edge_mag, got.edge_mag);
            end
            if (got.row_end !== exp_w.row_end)
            begin
                errors++;
                $display("%0t: row_end expected %0b got %0b",
                         $time, exp_w.row_end, got.row_end);
            end
            if (got.frame_end !== exp_w.frame_end)
            begin
                errors++;
                $display("%0t: frame_end expected %0b got %0b",
                         $time, exp_w.frame_end, got.frame_end);
            end
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    in_word_t         in_data   = '0;
    logic             in_ready;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_word_t        out_data;
    logic             cfg_valid = 1'b0;
    logic [0:0]       cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             cfg_ready;

    int               src_idle    = 0;
    int               snk_idle    = 0;
    bit               hold_output = 1'b0;
    int unsigned      stim_words  = 0;
    int unsigned      settings    = 0;
    int unsigned      cycle_count = 0;
    mag_scoreboard    sb;

    sobel_edge_magnitude DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.take_word(in_data);
            if (out_valid && out_ready)
                sb.check_word(out_data);
        end
    end

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic int idle_level();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    function automatic int pick_pixel(int style, int base);
        int v;
        case (style)
            0:       v = $urandom_range(0, 255);
            1:       v = base + int'($urandom_range(0, 24)) - 12;
            default: v = $urandom_range(0, 1) ? 255 : 0;
        endcase
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    function automatic in_word_t make_word(logic op, int px);
        in_word_t w;
        w.opcode   = op;
        w.pixel_in = px[PIX_W-1:0];
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        gap = pick_gap(src_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic configure(input int unsigned w, input int unsigned h);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= w[CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= h[CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.mag_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_frame(input int unsigned wd, input int unsigned count, input bit drain);
        int style, base, n;
        style = $urandom_range(0, 2);
        base  = $urandom_range(0, 255);
        for (int p = 0; p < count; p++)
        begin
            if ($urandom_range(0, 49) == 0)
                send_word(make_word(OP_FLUSH, $urandom_range(0, 255)));
            send_word(make_word(OP_PIXEL, pick_pixel(style, base)));
            stim_words++;
        end
        if (drain)
        begin
            n = wd + 1;
            if ($urandom_range(0, 19) == 0)
                n = n - $urandom_range(1, 2);
            repeat (n)
            begin
                send_word(make_word($urandom_range(0, 1) ? OP_FLUSH : OP_PIXEL,
                                    $urandom_range(0, 255)));
                stim_words++;
            end
            if ($urandom_range(0, 9) == 0)
                send_word(make_word(OP_FLUSH, $urandom_range(0, 255)));
        end
    endtask

    initial
    begin : output_side
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                hold_output = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = pick_gap(snk_idle);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int unsigned w, h, ew, eh, frames, start;
        bit          cut;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flush words with nothing to drain are dropped
        send_word(make_word(OP_FLUSH, 255));
        send_word(make_word(OP_FLUSH, 0));
        settle();

        configure(3, 3);
        for (int kind = 0; kind < 2; kind++)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    send_word(make_word(OP_PIXEL, (kind == 0) ?
                              ((c == 2 || r == 0) ? 255 : 0) :
                              (((r + c) % 2 != 0) ? 255 : 0)));
            // drain with pixel words mixed in, then one surplus flush
            for (int d = 0; d < 4; d++)
                send_word(make_word((d % 2 != 0) ? OP_PIXEL : OP_FLUSH, 8'hA5));
            send_word(make_word(OP_FLUSH, 8'h5A));
        end
        settle();

        // output held off while a full frame keeps coming: input must stall
        src_idle = 15;
        snk_idle = 15;
        configure(8, 6);
        hold_output = 1'b1;
        run_frame(8, 48, 1'b1);
        settle();
        configure(3, 8191);
        run_frame(3, 30, 1'b0);
        settle();

        start = stim_words;
        while (stim_words - start < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 2);
                1, 2:    w = $urandom_range(11, 24);
                default: w = $urandom_range(3, 10);
            endcase
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            ew = mag_scoreboard::clamp_dim(w, MAX_WIDTH);
            eh = mag_scoreboard::clamp_dim(h, MAX_HEIGHT);
            src_idle = idle_level();
            snk_idle = idle_level();
            configure(w, h);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                cut = (f == frames - 1) && ($urandom_range(0, 9) == 0);
                if (cut)
                    run_frame(ew, $urandom_range(1, ew * eh - 1), 1'b0);
                else
                    run_frame(ew, ew * eh, 1'b1);
            end
            settle();
        end

        $display("covered %0d frame settings, %0d input words, %0d magnitudes checked",
                 settings, sb.words, sb.checked);
        $display("incl. clamped sizes, drains, and a long output stall backing up the input");
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
